// ===== hw/rtl/ssa_pkg.sv =====
package ssa_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int POS_WIDTH = $clog2(DIGIT_COUNT);
   localparam int VALUE_WIDTH = 24;
   localparam int SHOWN_WIDTH = 15;
   localparam int WRAPPED_WIDTH = 14;
   localparam int PAIR_WIDTH = 7;
   localparam int DIGIT_WIDTH = 4;
   localparam int CODE_WIDTH = 8;
   localparam int DWELL_WIDTH = 8;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [POS_WIDTH-1:0] DOT_FIRST = 2'd0;
   localparam logic [POS_WIDTH-1:0] DOT_SECOND = 2'd1;
   localparam logic [POS_WIDTH-1:0] DOT_THIRD = 2'd2;
   localparam logic [POS_WIDTH-1:0] DOT_FOURTH = 2'd3;

   localparam logic [VALUE_WIDTH-1:0] LIMIT_THREE_DECIMALS = 24'd9900;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_TWO_DECIMALS = 24'd99900;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_ONE_DECIMAL = 24'd999900;

   // Reciprocals that give exact truncating quotients for any 32-bit dividend.
   localparam logic [31:0] RECIP_DIV10 = 32'hCCCCCCCD;
   localparam logic [31:0] RECIP_DIV100 = 32'h51EB851F;
   localparam logic [31:0] RECIP_DIV1000 = 32'h10624DD3;
   localparam int SHIFT_DIV10 = 35;
   localparam int SHIFT_DIV100 = 37;
   localparam int SHIFT_DIV1000 = 38;

   localparam logic [SHOWN_WIDTH-1:0] WRAP_LIMIT = 15'd10000;

   // Exact quotient by 100 for values below 10000.
   localparam logic [26:0] RECIP_PAIR = 27'd5243;
   localparam int SHIFT_PAIR = 19;
   localparam logic [WRAPPED_WIDTH-1:0] PAIR_BASE = 14'd100;

   // Exact quotient by 10 for values below 100.
   localparam logic [13:0] RECIP_TENS = 14'd103;
   localparam int SHIFT_TENS = 10;
   localparam logic [PAIR_WIDTH-1:0] TENS_BASE = 7'd10;

   localparam logic [CODE_WIDTH-1:0] CODE_BLANK = 8'hFF;
   localparam logic [CODE_WIDTH-1:0] DOT_CLEAR_MASK = 8'h7F;
   localparam logic [DWELL_WIDTH-1:0] DWELL_RESET = 8'd3;

   typedef struct packed {
      logic kind;
      logic [POS_WIDTH-1:0] dot;
      logic [SHOWN_WIDTH-1:0] shown;
   } scaled_type;

   typedef struct packed {
      logic kind;
      logic [POS_WIDTH-1:0] dot;
      logic [PAIR_WIDTH-1:0] high_pair;
      logic [PAIR_WIDTH-1:0] low_pair;
   } split_type;

   function automatic logic [CODE_WIDTH-1:0] glyph_code(input logic [DIGIT_WIDTH-1:0] digit);
      logic [CODE_WIDTH-1:0] code;
      case (digit)
         4'd0: code = 8'hC0;
         4'd1: code = 8'hF9;
         4'd2: code = 8'hA4;
         4'd3: code = 8'hB0;
         4'd4: code = 8'h99;
         4'd5: code = 8'h92;
         4'd6: code = 8'h82;
         4'd7: code = 8'hF8;
         4'd8: code = 8'h80;
         4'd9: code = 8'h90;
         default: code = CODE_BLANK;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/seven_segment_scan_with_auto_point_top.sv =====
// Four-digit common-anode seven-segment scanner with an automatic decimal point.
// The req channel carries one item per transfer: req_kind low loads req_value_milli
// (a number in thousandths), req_kind high is one time tick. Every item gives one
// transfer on the rsp channel: the active-low segment byte and the active-low digit
// select of the digit lit after that item. Values wrap above 9999 shown units.
// The csr channel writes the number of ticks each digit stays lit; csr_ready is
// always high. The user must write it only while no item is in flight; the block
// does not enforce this. The path is five registers deep (input, scaling
// multiply, wrap, digit-pair split, result), and one item is taken every cycle
// as long as rsp is not stalled.
// While rsp_stall is high the result holds, the pipeline fills up to five items,
// and then req_stall rises until the result is taken.
// Reset blanks all digits, returns the scan to the leftmost digit, clears the
// dwell count and sets the dwell to three ticks.
module seven_segment_scan_with_auto_point_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_kind,
   input  logic [23:0] req_value_milli,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_segments,
   output logic [3:0] rsp_digit_enable,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_dwell_ticks
);
   import ssa_pkg::*;

   logic scaled_valid;
   logic scaled_ready;
   scaled_type scaled_data;
   logic split_valid;
   logic split_ready;
   split_type split_data;

   ssa_scale u_scale (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_stall(req_stall),
      .in_kind(req_kind),
      .in_value(req_value_milli),
      .out_valid(scaled_valid),
      .out_ready(scaled_ready),
      .out_data(scaled_data)
   );

   ssa_split u_split (
      .clock(clock),
      .reset(reset),
      .in_valid(scaled_valid),
      .in_ready(scaled_ready),
      .in_data(scaled_data),
      .out_valid(split_valid),
      .out_ready(split_ready),
      .out_data(split_data)
   );

   ssa_display u_display (
      .clock(clock),
      .reset(reset),
      .in_valid(split_valid),
      .in_ready(split_ready),
      .in_data(split_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_dwell_ticks(csr_dwell_ticks),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_segments(rsp_segments),
      .rsp_digit_enable(rsp_digit_enable)
   );

endmodule

// ===== hw/rtl/ssa_scale.sv =====
module ssa_scale (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  logic in_kind,
   input  logic [23:0] in_value,
   output logic out_valid,
   input  logic out_ready,
   output ssa_pkg::scaled_type out_data
);
   import ssa_pkg::*;

   logic a_valid_ff, a_valid_in;
   logic a_kind_ff, a_kind_in;
   logic [POS_WIDTH-1:0] a_dot_ff, a_dot_in;
   logic [VALUE_WIDTH-1:0] a_value_ff, a_value_in;
   logic b_valid_ff, b_valid_in;
   scaled_type b_data_ff, b_data_in;
   logic a_ready;
   logic b_ready;
   logic [POS_WIDTH-1:0] in_dot;
   logic [31:0] recip;
   logic [55:0] product;
   logic [SHOWN_WIDTH-1:0] shown;

   assign b_ready = !b_valid_ff || out_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign in_stall = !a_ready;

   always_comb begin
      if (in_value <= LIMIT_THREE_DECIMALS) begin
         in_dot = DOT_FIRST;
      end else if (in_value <= LIMIT_TWO_DECIMALS) begin
         in_dot = DOT_SECOND;
      end else if (in_value <= LIMIT_ONE_DECIMAL) begin
         in_dot = DOT_THIRD;
      end else begin
         in_dot = DOT_FOURTH;
      end
   end

   always_comb begin
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      a_kind_in = a_kind_ff;
      a_dot_in = a_dot_ff;
      a_value_in = a_value_ff;
      if (a_ready && in_valid) begin
         a_kind_in = in_kind;
         a_dot_in = in_dot;
         a_value_in = in_value;
      end
   end

   always_comb begin
      case (a_dot_ff)
         DOT_SECOND: recip = RECIP_DIV10;
         DOT_THIRD: recip = RECIP_DIV100;
         default: recip = RECIP_DIV1000;
      endcase
   end

   assign product = {32'd0, a_value_ff} * {24'd0, recip};

   always_comb begin
      case (a_dot_ff)
         DOT_FIRST: shown = a_value_ff[SHOWN_WIDTH-1:0];
         DOT_SECOND: shown = product[SHIFT_DIV10 +: SHOWN_WIDTH];
         DOT_THIRD: shown = product[SHIFT_DIV100 +: SHOWN_WIDTH];
         default: shown = product[SHIFT_DIV1000 +: SHOWN_WIDTH];
      endcase
   end

   always_comb begin
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_data_in = b_data_ff;
      if (b_ready && a_valid_ff) begin
         b_data_in.kind = a_kind_ff;
         b_data_in.dot = a_dot_ff;
         b_data_in.shown = shown;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_kind_ff <= a_kind_in;
      a_dot_ff <= a_dot_in;
      a_value_ff <= a_value_in;
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data = b_data_ff;

endmodule

// ===== hw/rtl/ssa_split.sv =====
module ssa_split (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  ssa_pkg::scaled_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output ssa_pkg::split_type out_data
);
   import ssa_pkg::*;

   logic c_valid_ff, c_valid_in;
   logic c_kind_ff, c_kind_in;
   logic [POS_WIDTH-1:0] c_dot_ff, c_dot_in;
   logic [WRAPPED_WIDTH-1:0] c_wrapped_ff, c_wrapped_in;
   logic d_valid_ff, d_valid_in;
   split_type d_data_ff, d_data_in;
   logic d_ready;
   logic [SHOWN_WIDTH-1:0] wrapped_full;
   logic [26:0] pair_product;
   logic [PAIR_WIDTH-1:0] high_pair;
   logic [WRAPPED_WIDTH-1:0] low_full;

   assign d_ready = !d_valid_ff || out_ready;
   assign in_ready = !c_valid_ff || d_ready;

   // Values of 10000 and more keep only their low four decimal digits.
   assign wrapped_full = (in_data.shown >= WRAP_LIMIT) ? in_data.shown - WRAP_LIMIT
                                                       : in_data.shown;

   always_comb begin
      c_valid_in = in_ready ? in_valid : c_valid_ff;
      c_kind_in = c_kind_ff;
      c_dot_in = c_dot_ff;
      c_wrapped_in = c_wrapped_ff;
      if (in_ready && in_valid) begin
         c_kind_in = in_data.kind;
         c_dot_in = in_data.dot;
         c_wrapped_in = wrapped_full[WRAPPED_WIDTH-1:0];
      end
   end

   assign pair_product = 27'(c_wrapped_ff) * RECIP_PAIR;
   assign high_pair = pair_product[SHIFT_PAIR +: PAIR_WIDTH];
   assign low_full = c_wrapped_ff - WRAPPED_WIDTH'(high_pair) * PAIR_BASE;

   always_comb begin
      d_valid_in = d_ready ? c_valid_ff : d_valid_ff;
      d_data_in = d_data_ff;
      if (d_ready && c_valid_ff) begin
         d_data_in.kind = c_kind_ff;
         d_data_in.dot = c_dot_ff;
         d_data_in.high_pair = high_pair;
         d_data_in.low_pair = low_full[PAIR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_kind_ff <= c_kind_in;
      c_dot_ff <= c_dot_in;
      c_wrapped_ff <= c_wrapped_in;
      d_data_ff <= d_data_in;
   end

   assign out_valid = d_valid_ff;
   assign out_data = d_data_ff;

`ifndef SYNTHESIS
   a_wrapped_range: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> c_wrapped_ff < 14'd10000)
      else $error("Wrapped value is not below 10000.");

   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (d_data_ff.high_pair <= 7'd99 && d_data_ff.low_pair <= 7'd99))
      else $error("Digit pair is out of range.");
`endif

endmodule

// ===== hw/rtl/ssa_display.sv =====
module ssa_display (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  ssa_pkg::split_type in_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_dwell_ticks,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_segments,
   output logic [3:0] rsp_digit_enable
);
   import ssa_pkg::*;

   logic [DWELL_WIDTH-1:0] dwell_ticks_ff, dwell_ticks_in;
   logic [CODE_WIDTH-1:0] digit_codes_ff [DIGIT_COUNT];
   logic [CODE_WIDTH-1:0] digit_codes_in [DIGIT_COUNT];
   logic [POS_WIDTH-1:0] scan_ff, scan_in;
   logic [DWELL_WIDTH-1:0] dwell_count_ff, dwell_count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0] rsp_segments_ff, rsp_segments_in;
   logic [DIGIT_COUNT-1:0] rsp_digit_enable_ff, rsp_digit_enable_in;
   logic commit;
   logic [DWELL_WIDTH:0] dwell_next;
   logic tick_moves;
   logic [13:0] high_tens_product;
   logic [13:0] low_tens_product;
   logic [DIGIT_WIDTH-1:0] high_tens;
   logic [DIGIT_WIDTH-1:0] low_tens;
   logic [PAIR_WIDTH-1:0] high_units;
   logic [PAIR_WIDTH-1:0] low_units;
   logic [DIGIT_WIDTH-1:0] digits [DIGIT_COUNT];
   logic [CODE_WIDTH-1:0] new_codes [DIGIT_COUNT];

   assign in_ready = !rsp_valid_ff || !rsp_stall;
   assign commit = in_valid && in_ready;
   assign csr_ready = 1'b1;

   assign dwell_ticks_in = (csr_valid && csr_ready) ? csr_dwell_ticks : dwell_ticks_ff;

   assign high_tens_product = 14'(in_data.high_pair) * RECIP_TENS;
   assign low_tens_product = 14'(in_data.low_pair) * RECIP_TENS;
   assign high_tens = high_tens_product[SHIFT_TENS +: DIGIT_WIDTH];
   assign low_tens = low_tens_product[SHIFT_TENS +: DIGIT_WIDTH];
   assign high_units = in_data.high_pair - PAIR_WIDTH'(high_tens) * TENS_BASE;
   assign low_units = in_data.low_pair - PAIR_WIDTH'(low_tens) * TENS_BASE;

   always_comb begin
      digits[0] = high_tens;
      digits[1] = high_units[DIGIT_WIDTH-1:0];
      digits[2] = low_tens;
      digits[3] = low_units[DIGIT_WIDTH-1:0];
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         new_codes[i] = glyph_code(digits[i]);
         if (in_data.dot == POS_WIDTH'(i)) begin
            new_codes[i] = new_codes[i] & DOT_CLEAR_MASK;
         end
      end
   end

   // A dwell of zero moves the scan on every tick, the same as a dwell of one.
   assign dwell_next = {1'b0, dwell_count_ff} + 1'b1;
   assign tick_moves = dwell_next >= {1'b0, dwell_ticks_ff};

   always_comb begin
      digit_codes_in = digit_codes_ff;
      scan_in = scan_ff;
      dwell_count_in = dwell_count_ff;
      if (commit) begin
         if (in_data.kind == KIND_LOAD) begin
            digit_codes_in = new_codes;
         end else if (tick_moves) begin
            dwell_count_in = '0;
            scan_in = scan_ff + 1'b1;
         end else begin
            dwell_count_in = dwell_next[DWELL_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_segments_in = rsp_segments_ff;
      rsp_digit_enable_in = rsp_digit_enable_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_segments_in = digit_codes_in[scan_in];
         rsp_digit_enable_in = ~(DIGIT_COUNT'(1) << scan_in);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff <= DWELL_RESET;
         scan_ff <= '0;
         dwell_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_codes_ff[i] <= CODE_BLANK;
         end
      end else begin
         dwell_ticks_ff <= dwell_ticks_in;
         scan_ff <= scan_in;
         dwell_count_ff <= dwell_count_in;
         rsp_valid_ff <= rsp_valid_in;
         digit_codes_ff <= digit_codes_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_segments_ff <= rsp_segments_in;
      rsp_digit_enable_ff <= rsp_digit_enable_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_segments = rsp_segments_ff;
   assign rsp_digit_enable = rsp_digit_enable_ff;

`ifndef SYNTHESIS
   a_select_one_hot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(~rsp_digit_enable_ff))
      else $error("Digit select is not one-hot low.");

   a_load_keeps_scan: assert property (@(posedge clock) disable iff (reset)
      (!reset && commit && in_data.kind == KIND_LOAD) |=>
         (scan_ff == $past(scan_ff) && dwell_count_ff == $past(dwell_count_ff)))
      else $error("A load transfer moved the scan.");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (!reset && commit && in_data.kind == KIND_TICK && tick_moves) |=>
         (dwell_count_ff == '0 && scan_ff == POS_WIDTH'($past(scan_ff) + 1'b1)))
      else $error("The scan did not advance at the end of a dwell.");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      (!reset && commit) |=> rsp_valid_ff)
      else $error("A committed item produced no result.");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ssa_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PERCENT = 13;
   localparam int LOAD_PERCENT = 35;
   localparam int DOT_BIT = 7;
   localparam int MISMATCH_REPORTS = 10;
   localparam int PHASE_COUNT = 6;
   localparam int DIRECTED_COUNT = 25;

   localparam logic [10*CODE_WIDTH-1:0] GLYPH_ROM = {
      8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
   };

   typedef struct packed {
      logic [CODE_WIDTH-1:0] segments;
      logic [DIGIT_COUNT-1:0] digit_enable;
   } lit_digit_type;

   typedef struct packed {
      logic kind;
      logic [VALUE_WIDTH-1:0] value;
      logic pinned;
      lit_digit_type lit;
   } directed_row_type;

   // Pinned rows carry the digit that must be lit; the rest go through the predictor.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{KIND_TICK, 24'd0,        1'b1, '{8'hFF, 4'b1110}},
      '{KIND_LOAD, 24'd0,        1'b1, '{8'h40, 4'b1110}},
      '{KIND_TICK, 24'd0,        1'b1, '{8'h40, 4'b1110}},
      '{KIND_TICK, 24'hFFFFFF,   1'b1, '{8'hC0, 4'b1101}},
      '{KIND_LOAD, 24'd9900,     1'b1, '{8'h90, 4'b1101}},
      '{KIND_LOAD, 24'd9901,     1'b1, '{8'h10, 4'b1101}},
      '{KIND_LOAD, 24'd99900,    1'b1, '{8'h10, 4'b1101}},
      '{KIND_LOAD, 24'd99901,    1'b1, '{8'h90, 4'b1101}},
      '{KIND_LOAD, 24'd999900,   1'b1, '{8'h90, 4'b1101}},
      '{KIND_LOAD, 24'd999901,   1'b0, '0},
      '{KIND_LOAD, 24'd9999999,  1'b0, '0},
      '{KIND_LOAD, 24'hFFFFFF,   1'b0, '0},
      '{KIND_LOAD, 24'd10000000, 1'b0, '0},
      '{KIND_LOAD, 24'd1234567,  1'b0, '0},
      '{KIND_LOAD, 24'h555555,   1'b0, '0},
      '{KIND_LOAD, 24'hAAAAAA,   1'b0, '0},
      '{KIND_TICK, 24'h555555,   1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0},
      '{KIND_TICK, 24'd0,        1'b0, '0}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = KIND_LOAD;
   logic [VALUE_WIDTH-1:0] req_value_milli = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CODE_WIDTH-1:0] rsp_segments;
   logic [DIGIT_COUNT-1:0] rsp_digit_enable;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [DWELL_WIDTH-1:0] csr_dwell_ticks = '0;

   logic req_pinned = 1'b0;
   lit_digit_type req_lit = '0;
   logic idling_on = 1'b1;

   logic [CODE_WIDTH-1:0] shown_codes [DIGIT_COUNT];
   logic [POS_WIDTH-1:0] lit_pos;
   logic [DWELL_WIDTH-1:0] tick_count;
   logic [DWELL_WIDTH-1:0] dwell_setting;
   lit_digit_type pending_digits [$];
   int mismatch_count = 0;
   int quiet_cycles = 0;

   seven_segment_scan_with_auto_point_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_value_milli(req_value_milli),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_segments(rsp_segments),
      .rsp_digit_enable(rsp_digit_enable),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_dwell_ticks(csr_dwell_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic lit_digit_type advance_display(input logic kind,
                                                     input logic [VALUE_WIDTH-1:0] value);
      int unsigned shown;
      int dot_pos;
      int pos;
      logic [CODE_WIDTH-1:0] code;
      lit_digit_type lit;
      if (kind == KIND_LOAD) begin
         if (value <= LIMIT_THREE_DECIMALS) begin
            shown = 32'(value);
            dot_pos = 0;
         end else if (value <= LIMIT_TWO_DECIMALS) begin
            shown = 32'(value) / 10;
            dot_pos = 1;
         end else if (value <= LIMIT_ONE_DECIMAL) begin
            shown = 32'(value) / 100;
            dot_pos = 2;
         end else begin
            shown = 32'(value) / 1000;
            dot_pos = 3;
         end
         for (pos = DIGIT_COUNT - 1; pos >= 0; pos--) begin
            code = GLYPH_ROM[(shown % 10) * CODE_WIDTH +: CODE_WIDTH];
            if (pos == dot_pos) begin
               code[DOT_BIT] = 1'b0;
            end
            shown_codes[pos] = code;
            shown = shown / 10;
         end
      end else if (int'(tick_count) + 1 >= int'(dwell_setting)) begin
         tick_count = '0;
         lit_pos = lit_pos + 1'b1;
      end else begin
         tick_count = tick_count + 1'b1;
      end
      lit.segments = shown_codes[lit_pos];
      lit.digit_enable = ~(4'b0001 << lit_pos);
      return lit;
   endfunction

   always @(posedge clock) begin
      lit_digit_type predicted;
      lit_digit_type oldest;
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            shown_codes[i] = CODE_BLANK;
         end
         lit_pos = '0;
         tick_count = '0;
         dwell_setting = DWELL_RESET;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (csr_valid && csr_ready) begin
            dwell_setting = csr_dwell_ticks;
            quiet_cycles = 0;
         end
         if (req_valid && !req_stall) begin
            predicted = advance_display(req_kind, req_value_milli);
            pending_digits.push_back(req_pinned ? req_lit : predicted);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pending_digits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_REPORTS) begin
                  $display("%0t: unexpected transfer segments %h digit_enable %b",
                           $time, rsp_segments, rsp_digit_enable);
               end
            end else begin
               oldest = pending_digits.pop_front();
               if (rsp_segments !== oldest.segments ||
                   rsp_digit_enable !== oldest.digit_enable) begin
                  mismatch_count++;
                  if (mismatch_count <= MISMATCH_REPORTS) begin
                     $display("%0t: segments exp %h got %h, digit_enable exp %b got %b",
                              $time, oldest.segments, rsp_segments,
                              oldest.digit_enable, rsp_digit_enable);
                  end
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[seven_segment_scan_with_auto_point_top] ERROR");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && idling_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic send_item(input logic kind, input logic [VALUE_WIDTH-1:0] value,
                            input logic pinned, input lit_digit_type lit);
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value_milli <= value;
      req_pinned <= pinned;
      req_lit <= lit;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      logic kind;
      logic [VALUE_WIDTH-1:0] value;
      logic [VALUE_WIDTH-1:0] limit;
      kind = ($urandom_range(99) < LOAD_PERCENT) ? KIND_LOAD : KIND_TICK;
      case ($urandom_range(6))
         0: value = VALUE_WIDTH'($urandom_range(9900));
         1: value = VALUE_WIDTH'($urandom_range(99900, 9901));
         2: value = VALUE_WIDTH'($urandom_range(999900, 99901));
         3: value = VALUE_WIDTH'($urandom_range(9999999, 999901));
         4: value = VALUE_WIDTH'($urandom_range(24'hFFFFFF, 10000000));
         5: begin
            case ($urandom_range(2))
               0: limit = LIMIT_THREE_DECIMALS;
               1: limit = LIMIT_TWO_DECIMALS;
               default: limit = LIMIT_ONE_DECIMAL;
            endcase
            value = VALUE_WIDTH'(32'(limit) - 1 + $urandom_range(2));
         end
         default: value = VALUE_WIDTH'($urandom());
      endcase
      send_item(kind, value, 1'b0, '0);
   endtask

   // Every item returns one transfer, so an empty queue means the pipeline is empty.
   task automatic drain_display();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_digits.size() != 0);
      @(posedge clock);
   endtask

   task automatic retune_dwell(input logic [DWELL_WIDTH-1:0] dwell);
      drain_display();
      csr_valid <= 1'b1;
      csr_dwell_ticks <= dwell;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [DWELL_WIDTH-1:0] phase_dwell [PHASE_COUNT];
      int phase_items [PHASE_COUNT];
      directed_row_type row;
      phase_dwell = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd0, 8'd7};
      phase_dwell[4] = DWELL_WIDTH'($urandom_range(254, 3));
      phase_items = '{200, 150, 450, 200, 250, 250};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         send_item(row.kind, row.value, row.pinned, row.lit);
      end
      for (int p = 0; p < PHASE_COUNT; p++) begin
         retune_dwell(phase_dwell[p]);
         idling_on <= (p != 2);
         repeat (phase_items[p]) send_random_item();
      end
      drain_display();
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += pending_digits.size();
      if (mismatch_count == 0) begin
         $display("[seven_segment_scan_with_auto_point_top] OK");
      end else begin
         $display("[seven_segment_scan_with_auto_point_top] ERROR");
      end
      $finish;
   end

endmodule
